@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/glzw_pkg.sv @@
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Beat types, status codes and sizing constants shared by the decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int unsigned MaxCodes = 4096;
  localparam int unsigned MaxWidth = 12;
  localparam int unsigned CodeBits = 12;

  typedef enum logic [2:0] {
    StIndex   = 3'd0,
    StTaken   = 3'd1,
    StNeed    = 3'd2,
    StEnd     = 3'd3,
    StInvalid = 3'd4,
    StRefused = 3'd5
  } status_e;

  typedef enum logic {
    CmdFeed = 1'b0,
    CmdPull = 1'b1
  } command_e;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_index;
    logic [2:0] status;
  } out_beat_t;

  localparam logic [1:0] RegRootBits = 2'd0;

endpackage

@@ rtl/gif_lzw_decoder.sv @@
// Sequence: a feed beat's answer goes through SOut into the output register; a pull that
// pops a stacked index passes SDecode, SPopWait and SOut, and one that decodes a code
// first walks its prefix chain, each step a table read in SWalk and a push in SWalkWait.
// A clear code or a first root code met on the way adds an SDecode pass. Throughput:
// one beat in flight; in_stall_o stays high until the answer leaves the output register.
// Reset is asynchronous, active low, and leaves root bits at 8; tables need no clearing.
// ----------------------------------------------------------------------------
// GIF LZW decoder
// Expands a GIF LZW code stream into palette indices, one beat at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gif_lzw_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  glzw_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output glzw_pkg::out_beat_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // The sequencer. Decode reads the head code from the bit buffer, Walk/WalkWait follow
  // the prefix chain, a dictionary read and a stack push per step; PopWait reads the string stack.
  typedef enum logic [2:0] {
    SIdle, SDecode, SWalk, SWalkWait, SPopWait, SOut
  } state_e;

  state_e      state_q;
  logic [3:0]  root_q;
  logic [12:0] stack_cnt_q;
  logic [19:0] bitbuf_q;
  logic [4:0]  held_q;
  logic [3:0]  width_q;
  logic [12:0] nfc_q;
  logic [11:0] prev_code_q;
  logic        prev_valid_q;
  logic [7:0]  prev_first_q;
  logic [1:0]  stop_q;
  logic [11:0] cur_q;       // code being walked
  logic [11:0] code_q;      // code decoded this step
  logic        add_q;       // an entry is added once the walk ends
  logic        out_valid_q;
  glzw_pkg::out_beat_t out_q;

  // Memories: dictionary and string stack.
  logic [11:0] prefix_mem [glzw_pkg::MaxCodes];
  logic [7:0]  suffix_mem [glzw_pkg::MaxCodes];
  logic [7:0]  stack_mem  [glzw_pkg::MaxCodes];
  logic [11:0] pre_rd_q;
  logic [7:0]  suf_rd_q;
  logic [7:0]  stk_rd_q;

  // Effective root bits, clamped to the legal range.
  logic [3:0]  eroot;
  logic [12:0] clear_code;
  logic [12:0] first_entry;
  always_comb begin
    eroot = root_q;
    if (root_q < 4'd2) eroot = 4'd2;
    if (root_q > 4'd8) eroot = 4'd8;
    clear_code  = 13'd1 << eroot;
    first_entry = clear_code + 13'd2;
  end

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && (paddr == glzw_pkg::RegRootBits);
  assign pready = 1'b1;
  assign prdata = {28'd0, root_q};

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Head code of the bit buffer.
  logic [11:0] head_code;
  logic [11:0] wmask;
  assign wmask     = 12'((13'd1 << width_q) - 13'd1);
  assign head_code = bitbuf_q[11:0] & wmask;

  // Memory write and read ports, driven from the sequencer.
  logic        stk_we, dict_we;
  logic [11:0] stk_wa;
  logic [7:0]  stk_wd;
  logic [11:0] stk_ra, dict_ra;
  logic [7:0]  dict_suf_wd;

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stack_mem[stk_ra];
    if (dict_we) begin
      prefix_mem[nfc_q[11:0]] <= prev_code_q;
      suffix_mem[nfc_q[11:0]] <= dict_suf_wd;
    end
    pre_rd_q <= prefix_mem[dict_ra];
    suf_rd_q <= suffix_mem[dict_ra];
  end

  // Combinational step control.
  logic root_hit;
  assign root_hit = ({1'b0, cur_q} < first_entry);

  always_comb begin
    stk_we = 1'b0;
    stk_wa = stack_cnt_q[11:0];
    stk_wd = 8'd0;
    stk_ra = 12'(stack_cnt_q - 13'd1);
    dict_ra = cur_q;
    dict_we = 1'b0;
    dict_suf_wd = cur_q[7:0];
    case (state_q)
      SDecode: begin
        dict_ra = head_code;
        if (prev_valid_q && {1'b0, head_code} == nfc_q && !nfc_q[12]) begin
          stk_we = 1'b1;
          stk_wd = prev_first_q;
          dict_ra = prev_code_q;
        end else if (!prev_valid_q) begin
          stk_we = 1'b1;
          stk_wd = head_code[7:0];
        end
      end
      SWalk: begin
        dict_ra = cur_q;
        if (root_hit) begin
          stk_we = !stack_cnt_q[12];
          stk_wd = cur_q[7:0];
          dict_we = add_q && !nfc_q[12];
        end
      end
      SWalkWait: begin
        stk_we = !stack_cnt_q[12];
        stk_wd = suf_rd_q;
        dict_ra = pre_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      root_q       <= 4'd8;
      stack_cnt_q  <= '0;
      bitbuf_q     <= '0;
      held_q       <= '0;
      width_q      <= 4'd9;
      nfc_q        <= 13'd258;
      prev_code_q  <= '0;
      prev_valid_q <= 1'b0;
      prev_first_q <= '0;
      stop_q       <= '0;
      cur_q        <= '0;
      code_q       <= '0;
      add_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_wr) begin
        // Restart with the new root; clamp mirrors the effective root.
        root_q       <= pwdata[3:0];
        stack_cnt_q  <= '0;
        bitbuf_q     <= '0;
        held_q       <= '0;
        prev_code_q  <= '0;
        prev_valid_q <= 1'b0;
        prev_first_q <= '0;
        stop_q       <= '0;
        width_q      <= (pwdata[3:0] < 4'd2) ? 4'd3 :
                        (pwdata[3:0] > 4'd8) ? 4'd9 : pwdata[3:0] + 4'd1;
        nfc_q        <= (pwdata[3:0] < 4'd2) ? 13'd6 :
                        (pwdata[3:0] > 4'd8) ? 13'd258 :
                        (13'd1 << pwdata[3:0]) + 13'd2;
      end else begin
        case (state_q)
          SIdle: begin
            if (in_acc) begin
              if (in_data_i.command == glzw_pkg::CmdFeed) begin
                out_q.pixel_index <= '0;
                if (stop_q != 2'd0 || held_q > 5'd12) begin
                  out_q.status <= glzw_pkg::StRefused;
                end else begin
                  bitbuf_q <= 20'(bitbuf_q | (20'(in_data_i.data_byte) << held_q));
                  held_q   <= held_q + 5'd8;
                  out_q.status <= glzw_pkg::StTaken;
                end
                state_q <= SOut;
              end else begin
                state_q <= SDecode;
              end
            end
          end
          SDecode: begin
            out_q.pixel_index <= '0;
            if (stack_cnt_q != 13'd0) begin
              stack_cnt_q <= stack_cnt_q - 13'd1;
              state_q <= SPopWait;
            end else if (stop_q == 2'd1) begin
              out_q.status <= glzw_pkg::StEnd;
              state_q <= SOut;
            end else if (stop_q != 2'd0) begin
              out_q.status <= glzw_pkg::StInvalid;
              state_q <= SOut;
            end else if (held_q < {1'b0, width_q}) begin
              out_q.status <= glzw_pkg::StNeed;
              state_q <= SOut;
            end else begin
              bitbuf_q <= bitbuf_q >> width_q;
              held_q   <= held_q - {1'b0, width_q};
              if ({1'b0, head_code} == clear_code) begin
                width_q <= eroot + 4'd1;
                nfc_q <= first_entry;
                prev_valid_q <= 1'b0;
              end else if ({1'b0, head_code} == clear_code + 13'd1) begin
                stop_q <= 2'd1;
                out_q.status <= glzw_pkg::StEnd;
                state_q <= SOut;
              end else if (!prev_valid_q) begin
                if ({1'b0, head_code} >= clear_code) begin
                  stop_q <= 2'd2;
                  out_q.status <= glzw_pkg::StInvalid;
                  state_q <= SOut;
                end else begin
                  stack_cnt_q  <= stack_cnt_q + 13'd1;
                  prev_code_q  <= head_code;
                  prev_first_q <= head_code[7:0];
                  prev_valid_q <= 1'b1;
                end
              end else if ({1'b0, head_code} < nfc_q) begin
                cur_q <= head_code;
                code_q <= head_code;
                add_q <= !nfc_q[12];
                state_q <= SWalk;
              end else if ({1'b0, head_code} == nfc_q && !nfc_q[12]) begin
                stack_cnt_q <= stack_cnt_q + 13'd1;
                cur_q <= prev_code_q;
                code_q <= head_code;
                add_q <= 1'b1;
                state_q <= SWalk;
              end else begin
                stop_q <= 2'd2;
                out_q.status <= glzw_pkg::StInvalid;
                state_q <= SOut;
              end
            end
          end
          SWalk: begin
            if (root_hit) begin
              // Chain ends at a root: it is the first character.
              if (!stack_cnt_q[12]) stack_cnt_q <= stack_cnt_q + 13'd1;
              if (add_q && !nfc_q[12]) begin
                nfc_q <= nfc_q + 13'd1;
                if (nfc_q + 13'd1 == (13'd1 << width_q) && width_q < 4'(glzw_pkg::MaxWidth))
                  width_q <= width_q + 4'd1;
              end
              prev_code_q  <= code_q;
              prev_first_q <= cur_q[7:0];
              state_q <= SDecode;
            end else begin
              state_q <= SWalkWait;
            end
          end
          SWalkWait: begin
            if (!stack_cnt_q[12]) stack_cnt_q <= stack_cnt_q + 13'd1;
            cur_q <= pre_rd_q;
            state_q <= SWalk;
          end
          SPopWait: begin
            out_q.pixel_index <= stk_rd_q;
            out_q.status <= glzw_pkg::StIndex;
            state_q <= SOut;
          end
          SOut: begin
            out_valid_q <= 1'b1;
            state_q <= SIdle;
          end
          default: state_q <= SIdle;
        endcase
      end
    end
  end

  `ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, state_q != SIdle, in_stall_o, "accepted while busy")
  `ASSERT_IMPL(a_held_max, clk_i, rst_ni, 1'b1, held_q <= 5'd20, "bit count overflow")
  `ASSERT_IMPL(a_width_range, clk_i, rst_ni, 1'b1, width_q <= 4'd12 && width_q >= 4'd3, "width range")
  `ASSERT_NEXT(a_out_follows, clk_i, rst_ni, state_q == SOut, out_valid_q, "answer lost")

endmodule
